### src/ttw_pkg.sv
// Shared types and constants for the text terminal writer.
package ttw_pkg;

  localparam logic       CMD_PUT      = 1'b0;
  localparam logic       CMD_READ     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [10:0] cursor_position;
    logic        scrolled;
  } out_t;

endpackage

### src/ttw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### src/text_terminal_writer.sv
// Text terminal writer: character-cell store with cursor, put and read commands.
//
// A ROWS x COLUMNS store of 16-bit cells (attribute high byte, character low
// byte) sits in one RAM with a single write and a single registered read port;
// a small sequencer drives it one cell per cycle. A read or an ordinary put
// registers its result beat from a response state once the output is free. A
// put that runs the cursor off the bottom row scrolls: the sequencer walks
// every cell once before the result beat. After reset the store is swept to
// grey spaces (0x0720), and no input beat is taken until the last write of that
// sweep has landed; colour writes on cfg_we_i are taken at any time.
// in_ready_o is high only while the sequencer is idle.
module text_terminal_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ttw_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ttw_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_BASE_A = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] CELL_LAST_A = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_RESP_PUT,
    ST_RESP_READ
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   scr_q, scr_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic [7:0]          color_q, color_d;
  logic                wr_q, wr_d;
  logic [ADDR_W-1:0]   wr_addr_q, wr_addr_d;
  logic [15:0]         wr_data_q, wr_data_d;
  logic                wr_rd_q, wr_rd_d;
  logic                rd_ok_q, rd_ok_d;
  logic                scrolled_q, scrolled_d;
  logic                out_valid_q, out_valid_d;
  ttw_pkg::out_t       out_q, out_d;

  logic                re;
  logic [ADDR_W-1:0]   raddr;
  logic [15:0]         rdata;
  logic                accept;
  logic                out_free;
  logic                wrap_row;

  ttw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (wr_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wr_rd_q ? rdata : wr_data_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // the last sweep write lands in the first idle cycle; hold off until it has
  assign in_ready_o  = (state_q == ST_IDLE) && !wr_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    scr_d       = scr_q;
    row_d       = row_q;
    col_d       = col_q;
    pos_d       = pos_q;
    color_d     = cfg_we_i ? cfg_data_i : color_q;
    wr_d        = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    wr_rd_d     = 1'b0;
    rd_ok_d     = rd_ok_q;
    scrolled_d  = scrolled_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    re          = 1'b0;
    raddr       = scr_q + COLS_A;
    wrap_row    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_d      = 1'b1;
        wr_addr_d = scr_q;
        wr_data_d = {ttw_pkg::RESET_COLOR, ttw_pkg::SPACE_CODE};
        scr_d     = scr_q + 1'b1;
        if (scr_q == CELL_LAST_A) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        raddr = ADDR_W'(in_data_i.cell_address);
        if (accept) begin
          if (in_data_i.command == ttw_pkg::CMD_READ) begin
            re      = 1'b1;
            rd_ok_d = 32'(in_data_i.cell_address) < 32'(CELL_COUNT);
            state_d = ST_RESP_READ;
          end else begin
            if (in_data_i.char_code == ttw_pkg::NEWLINE_CODE) begin
              col_d    = '0;
              pos_d    = pos_q + COLS_A - ADDR_W'(col_q);
              wrap_row = 1'b1;
            end else begin
              wr_d      = 1'b1;
              wr_addr_d = pos_q;
              wr_data_d = {color_q, in_data_i.char_code};
              pos_d     = pos_q + 1'b1;
              if (col_q == COL_LAST) begin
                col_d    = '0;
                wrap_row = 1'b1;
              end else begin
                col_d = col_q + 1'b1;
              end
            end
            scrolled_d = wrap_row && (row_q == ROW_LAST);
            if (wrap_row && row_q == ROW_LAST) begin
              pos_d   = LAST_BASE_A;
              scr_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              if (wrap_row) begin
                row_d = row_q + 1'b1;
              end
              state_d = ST_RESP_PUT;
            end
          end
        end
      end

      ST_SCROLL: begin
        // copy each cell up from the row below into place, then fill the bottom row;
        // writes land in the cycle after their read
        wr_d      = 1'b1;
        wr_addr_d = scr_q;
        if (scr_q >= LAST_BASE_A) begin
          wr_data_d = {color_q, ttw_pkg::SPACE_CODE};
        end else begin
          re      = 1'b1;
          wr_rd_d = 1'b1;
        end
        scr_d = scr_q + 1'b1;
        if (scr_q == CELL_LAST_A) begin
          state_d = ST_RESP_PUT;
        end
      end

      ST_RESP_PUT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.cell_value      = '0;
          out_d.cursor_position = 11'(pos_q);
          out_d.scrolled        = scrolled_q;
          state_d               = ST_IDLE;
        end
      end

      ST_RESP_READ: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.cell_value      = rd_ok_q ? rdata : 16'h0000;
          out_d.cursor_position = 11'(pos_q);
          out_d.scrolled        = 1'b0;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scr_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      color_q     <= ttw_pkg::RESET_COLOR;
      wr_q        <= 1'b0;
      wr_addr_q   <= '0;
      wr_data_q   <= '0;
      wr_rd_q     <= 1'b0;
      rd_ok_q     <= 1'b0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      scr_q       <= scr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pos_q       <= pos_d;
      color_q     <= color_d;
      wr_q        <= wr_d;
      wr_addr_q   <= wr_addr_d;
      wr_data_q   <= wr_data_d;
      wr_rd_q     <= wr_rd_d;
      rd_ok_q     <= rd_ok_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule
